/* src/gdcg_pkg.sv */
// Shared types and constants for the gamepad drive-command guard.
package gdcg_pkg;

    // Width of the Q1.15 gains and smoothing coefficient.
    localparam int GAIN_W     = 16;
    // Width of the timeout register and the tick counter.
    localparam int TICK_W     = 10;
    // Configuration port widths.
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    // Reset values of the configuration registers.
    localparam logic [GAIN_W-1:0] SMOOTHING_COEFF_RST = 16'd3277;
    localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST   = 10'd15;
    localparam logic [GAIN_W-1:0] GAIN_RST            = 16'd32768;

    // Input item kinds.
    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TICK   = 1'b1
    } t_op;

    // Result item kinds.
    typedef enum logic {
        KIND_ENABLE = 1'b0,
        KIND_DRIVE  = 1'b1
    } t_kind;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SMOOTHING_COEFF = 3'd0,
        CFG_TIMEOUT_TICKS   = 3'd1,
        CFG_BRAKE_GAIN      = 3'd2,
        CFG_THROTTLE_GAIN   = 3'd3,
        CFG_STEERING_GAIN   = 3'd4
    } t_cfg_index;

endpackage

/* src/gdcg_trigger_map.sv */
// Maps a trigger axis to a scaled pedal level, gain * (1 - v) / 2, saturated to [0, 1].
module gdcg_trigger_map #(
    parameter int AXIS_BITS = 16
) (
    input  logic [gdcg_pkg::GAIN_W-1:0] i_gain,
    input  logic signed [AXIS_BITS-1:0] i_axis,
    output logic [AXIS_BITS-1:0]        o_level
);
    import gdcg_pkg::*;

    localparam int PW = GAIN_W + AXIS_BITS + 2;
    localparam logic [AXIS_BITS:0] ONE = {2'b01, {(AXIS_BITS-1){1'b0}}};
    localparam logic [PW-1:0] HALF = PW'(1) << 15;

    logic [AXIS_BITS:0]   travel;
    logic [PW-1:0]        prod;
    logic [PW-1:0]        rnd;
    logic [AXIS_BITS+1:0] scaled;

    // Travel is 1 - v, which lies between one LSB and 2.0.
    assign travel = ONE - {i_axis[AXIS_BITS-1], i_axis};
    assign prod   = PW'(i_gain) * PW'(travel);
    assign rnd    = prod + HALF;
    assign scaled = rnd[PW-1:16];

    assign o_level = (scaled > {1'b0, ONE}) ? ONE[AXIS_BITS-1:0] : scaled[AXIS_BITS-1:0];

endmodule

/* src/gdcg_steer_map.sv */
// Maps the steering axis to a scaled steering level, gain * (-v), saturated.
module gdcg_steer_map #(
    parameter int AXIS_BITS = 16
) (
    input  logic [gdcg_pkg::GAIN_W-1:0] i_gain,
    input  logic signed [AXIS_BITS-1:0] i_axis,
    output logic signed [AXIS_BITS-1:0] o_level
);
    import gdcg_pkg::*;

    localparam int PW = GAIN_W + AXIS_BITS + 1;
    localparam logic signed [AXIS_BITS-1:0] AX_MAX = {1'b0, {(AXIS_BITS-1){1'b1}}};
    localparam logic signed [AXIS_BITS-1:0] AX_MIN = {1'b1, {(AXIS_BITS-1){1'b0}}};
    localparam logic signed [AXIS_BITS+1:0] HI = {3'b000, {(AXIS_BITS-1){1'b1}}};
    localparam logic signed [AXIS_BITS+1:0] LO = {3'b111, {(AXIS_BITS-1){1'b0}}};
    localparam logic signed [PW-1:0] HALF = PW'(1) << 14;

    logic signed [AXIS_BITS-1:0] neg;
    logic signed [PW-1:0]        prod;
    logic signed [PW-1:0]        rnd;
    logic signed [AXIS_BITS+1:0] scaled;

    // Negating full-scale right would overflow, so it saturates to full left.
    assign neg    = (i_axis == AX_MIN) ? AX_MAX : -i_axis;
    assign prod   = $signed({1'b0, i_gain}) * neg;
    assign rnd    = prod + HALF;
    assign scaled = rnd[PW-1:15];

    always_comb begin
        if (scaled > HI) begin
            o_level = AX_MAX;
        end else if (scaled < LO) begin
            o_level = AX_MIN;
        end else begin
            o_level = scaled[AXIS_BITS-1:0];
        end
    end

endmodule

/* src/gdcg_smoother.sv */
// One update of the steering exponential average: avg + round(f * (level - avg)).
module gdcg_smoother #(
    parameter int AXIS_BITS = 16
) (
    input  logic [gdcg_pkg::GAIN_W-1:0] i_coeff,
    input  logic signed [AXIS_BITS-1:0] i_level,
    input  logic signed [AXIS_BITS-1:0] i_average,
    output logic signed [AXIS_BITS-1:0] o_average
);
    import gdcg_pkg::*;

    localparam int PW = GAIN_W + AXIS_BITS + 2;
    localparam logic signed [AXIS_BITS-1:0] AX_MAX = {1'b0, {(AXIS_BITS-1){1'b1}}};
    localparam logic signed [AXIS_BITS-1:0] AX_MIN = {1'b1, {(AXIS_BITS-1){1'b0}}};
    localparam logic signed [AXIS_BITS+3:0] HI = {5'b00000, {(AXIS_BITS-1){1'b1}}};
    localparam logic signed [AXIS_BITS+3:0] LO = {5'b11111, {(AXIS_BITS-1){1'b0}}};
    localparam logic signed [PW-1:0] HALF = PW'(1) << 14;

    logic signed [AXIS_BITS:0]   diff;
    logic signed [PW-1:0]        prod;
    logic signed [PW-1:0]        rnd;
    logic signed [AXIS_BITS+2:0] step;
    logic signed [AXIS_BITS+3:0] sum;

    // f*L + (1-f)*A equals A*2^15 + f*(L-A); the A*2^15 term is exact, so
    // only the difference term needs rounding.
    assign diff = {i_level[AXIS_BITS-1], i_level} - {i_average[AXIS_BITS-1], i_average};
    assign prod = $signed({1'b0, i_coeff}) * diff;
    assign rnd  = prod + HALF;
    assign step = rnd[PW-1:15];
    assign sum  = {step[AXIS_BITS+2], step} + {{4{i_average[AXIS_BITS-1]}}, i_average};

    always_comb begin
        if (sum > HI) begin
            o_average = AX_MAX;
        end else if (sum < LO) begin
            o_average = AX_MIN;
        end else begin
            o_average = sum[AXIS_BITS-1:0];
        end
    end

endmodule

/* src/gamepad_drive_command_guard.sv */
// Top level of the gamepad drive-command guard: handshakes, state and result register.
//
// The guard turns gamepad samples and publish ticks into enable messages and
// drive commands. A complete sample arms the guard once both triggers read
// above 0.99 of full scale; after that each complete sample sets the brake,
// throttle and steering levels and a rising edge of back (which wins) or
// start emits a disable or enable message. A tick while enabled emits a drive
// command carrying the smoothed steering, unless more than timeout_ticks
// ticks have passed since the last complete sample, in which case the guard
// zeroes its levels, disarms and emits a single disable message. Incomplete
// samples are dropped. The guard accepts one transaction per clock while
// o_in_stall is low; a transaction is captured in an input register and
// processed from there into the result register once that register is
// free or drained. The critical path is the steering average update:
// one 17 by AXIS_BITS+1 bit multiply, a round, an add and a clamp. Stall on
// the result side backs up into o_in_stall in the same cycle only when both
// registers are occupied. Configuration writes take effect at the next edge
// and should only be made while no transaction is in flight.
module gamepad_drive_command_guard #(
    parameter int AXIS_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_cfg_wr_en,
    input  logic [gdcg_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [gdcg_pkg::CFG_DATA_W-1:0]  i_cfg_wr_data,

    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_op,
    input  logic                             i_sample_complete,
    input  logic signed [AXIS_BITS-1:0]      i_brake_axis_value,
    input  logic signed [AXIS_BITS-1:0]      i_throttle_axis_value,
    input  logic signed [AXIS_BITS-1:0]      i_steering_axis_value,
    input  logic                             i_start_pressed,
    input  logic                             i_back_pressed,

    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_kind,
    output logic                             o_enable_value,
    output logic [AXIS_BITS-1:0]             o_brake_cmd,
    output logic [AXIS_BITS-1:0]             o_throttle_cmd,
    output logic signed [AXIS_BITS-1:0]      o_steering_cmd
);
    import gdcg_pkg::*;

    // Arming threshold, 0.99 of full scale, fixed at elaboration.
    localparam int ARM_THR = (99 * (1 << (AXIS_BITS - 1))) / 100;

    // Configuration registers.
    logic [GAIN_W-1:0] r_smoothing_coeff;
    logic [TICK_W-1:0] r_timeout_ticks;
    logic [GAIN_W-1:0] r_brake_gain;
    logic [GAIN_W-1:0] r_throttle_gain;
    logic [GAIN_W-1:0] r_steering_gain;

    // Input register.
    logic                        r_in_valid;
    logic                        r_op;
    logic                        r_sample_complete;
    logic signed [AXIS_BITS-1:0] r_brake_axis;
    logic signed [AXIS_BITS-1:0] r_throttle_axis;
    logic signed [AXIS_BITS-1:0] r_steering_axis;
    logic                        r_start;
    logic                        r_back;

    // Guard state.
    logic                        r_armed,            n_armed;
    logic                        r_enabled,          n_enabled;
    logic                        r_prev_start,       n_prev_start;
    logic                        r_prev_back,        n_prev_back;
    logic                        r_seen_sample,      n_seen_sample;
    logic [TICK_W-1:0]           r_ticks,            n_ticks;
    logic [AXIS_BITS-1:0]        r_brake_level,      n_brake_level;
    logic [AXIS_BITS-1:0]        r_throttle_level,   n_throttle_level;
    logic signed [AXIS_BITS-1:0] r_steering_level,   n_steering_level;
    logic signed [AXIS_BITS-1:0] r_steering_average, n_steering_average;

    // Result register.
    logic                        r_out_valid,     n_out_valid;
    logic                        r_kind,          n_kind;
    logic                        r_enable_value,  n_enable_value;
    logic [AXIS_BITS-1:0]        r_brake_cmd,     n_brake_cmd;
    logic [AXIS_BITS-1:0]        r_throttle_cmd,  n_throttle_cmd;
    logic signed [AXIS_BITS-1:0] r_steering_cmd,  n_steering_cmd;

    // Datapath results for the transaction in the input register.
    logic [AXIS_BITS-1:0]        brake_map;
    logic [AXIS_BITS-1:0]        throttle_map;
    logic signed [AXIS_BITS-1:0] steering_map;
    logic signed [AXIS_BITS-1:0] average_upd;

    logic advance;
    logic fire;
    logic emit;
    logic [TICK_W-1:0] ticks_inc;

    gdcg_trigger_map #(.AXIS_BITS(AXIS_BITS)) u_brake_map (
        .i_gain  (r_brake_gain),
        .i_axis  (r_brake_axis),
        .o_level (brake_map)
    );

    gdcg_trigger_map #(.AXIS_BITS(AXIS_BITS)) u_throttle_map (
        .i_gain  (r_throttle_gain),
        .i_axis  (r_throttle_axis),
        .o_level (throttle_map)
    );

    gdcg_steer_map #(.AXIS_BITS(AXIS_BITS)) u_steer_map (
        .i_gain  (r_steering_gain),
        .i_axis  (r_steering_axis),
        .o_level (steering_map)
    );

    gdcg_smoother #(.AXIS_BITS(AXIS_BITS)) u_smoother (
        .i_coeff   (r_smoothing_coeff),
        .i_level   (r_steering_level),
        .i_average (r_steering_average),
        .o_average (average_upd)
    );

    // The processing stage moves whenever the result register is free or
    // being drained this cycle.
    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    assign ticks_inc = (r_ticks == TICK_MAX) ? r_ticks : r_ticks + TICK_W'(1);

    // Next guard state and result for the transaction being processed.
    always_comb begin
        n_armed            = r_armed;
        n_enabled          = r_enabled;
        n_prev_start       = r_prev_start;
        n_prev_back        = r_prev_back;
        n_seen_sample      = r_seen_sample;
        n_ticks            = r_ticks;
        n_brake_level      = r_brake_level;
        n_throttle_level   = r_throttle_level;
        n_steering_level   = r_steering_level;
        n_steering_average = r_steering_average;
        emit               = 1'b0;
        n_kind             = KIND_ENABLE;
        n_enable_value     = 1'b0;
        n_brake_cmd        = '0;
        n_throttle_cmd     = '0;
        n_steering_cmd     = '0;

        if (fire) begin
            if (r_op == OP_SAMPLE) begin
                if (r_sample_complete) begin
                    n_seen_sample = 1'b1;
                    n_ticks       = '0;
                    if (!r_armed) begin
                        // The arming sample only checks the triggers.
                        n_armed = (int'(r_brake_axis) > ARM_THR) &&
                                  (int'(r_throttle_axis) > ARM_THR);
                    end else begin
                        n_brake_level    = brake_map;
                        n_throttle_level = throttle_map;
                        n_steering_level = steering_map;
                        if (!r_prev_back && r_back) begin
                            n_enabled      = 1'b0;
                            emit           = 1'b1;
                            n_enable_value = 1'b0;
                        end else if (!r_prev_start && r_start) begin
                            n_enabled      = 1'b1;
                            emit           = 1'b1;
                            n_enable_value = 1'b1;
                        end
                        n_prev_back  = r_back;
                        n_prev_start = r_start;
                    end
                end
            end else begin
                n_ticks = ticks_inc;
                if (r_enabled && r_seen_sample && (ticks_inc > r_timeout_ticks)) begin
                    // Samples have stopped: drop everything and disable.
                    n_brake_level      = '0;
                    n_throttle_level   = '0;
                    n_steering_level   = '0;
                    n_steering_average = '0;
                    n_armed            = 1'b0;
                    n_enabled          = 1'b0;
                    emit               = 1'b1;
                    n_enable_value     = 1'b0;
                end else if (r_enabled) begin
                    n_steering_average = average_upd;
                    emit               = 1'b1;
                    n_kind             = KIND_DRIVE;
                    n_brake_cmd        = r_brake_level;
                    n_throttle_cmd     = r_throttle_level;
                    n_steering_cmd     = average_upd;
                end
            end
        end
    end

    always_comb begin
        if (advance) begin
            n_out_valid = fire && emit;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smoothing_coeff <= SMOOTHING_COEFF_RST;
            r_timeout_ticks   <= TIMEOUT_TICKS_RST;
            r_brake_gain      <= GAIN_RST;
            r_throttle_gain   <= GAIN_RST;
            r_steering_gain   <= GAIN_RST;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_SMOOTHING_COEFF: r_smoothing_coeff <= i_cfg_wr_data[GAIN_W-1:0];
                CFG_TIMEOUT_TICKS:   r_timeout_ticks   <= i_cfg_wr_data[TICK_W-1:0];
                CFG_BRAKE_GAIN:      r_brake_gain      <= i_cfg_wr_data[GAIN_W-1:0];
                CFG_THROTTLE_GAIN:   r_throttle_gain   <= i_cfg_wr_data[GAIN_W-1:0];
                CFG_STEERING_GAIN:   r_steering_gain   <= i_cfg_wr_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register: loads whenever the input side is not stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_op              <= i_op;
            r_sample_complete <= i_sample_complete;
            r_brake_axis      <= i_brake_axis_value;
            r_throttle_axis   <= i_throttle_axis_value;
            r_steering_axis   <= i_steering_axis_value;
            r_start           <= i_start_pressed;
            r_back            <= i_back_pressed;
        end
    end

    // Guard state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed            <= 1'b0;
            r_enabled          <= 1'b0;
            r_prev_start       <= 1'b0;
            r_prev_back        <= 1'b0;
            r_seen_sample      <= 1'b0;
            r_ticks            <= '0;
            r_brake_level      <= '0;
            r_throttle_level   <= '0;
            r_steering_level   <= '0;
            r_steering_average <= '0;
        end else begin
            r_armed            <= n_armed;
            r_enabled          <= n_enabled;
            r_prev_start       <= n_prev_start;
            r_prev_back        <= n_prev_back;
            r_seen_sample      <= n_seen_sample;
            r_ticks            <= n_ticks;
            r_brake_level      <= n_brake_level;
            r_throttle_level   <= n_throttle_level;
            r_steering_level   <= n_steering_level;
            r_steering_average <= n_steering_average;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emit) begin
            r_kind         <= n_kind;
            r_enable_value <= n_enable_value;
            r_brake_cmd    <= n_brake_cmd;
            r_throttle_cmd <= n_throttle_cmd;
            r_steering_cmd <= n_steering_cmd;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_enable_value = r_enable_value;
    assign o_brake_cmd    = r_brake_cmd;
    assign o_throttle_cmd = r_throttle_cmd;
    assign o_steering_cmd = r_steering_cmd;

endmodule

/* tb/gdcg_checker.sv */
// Checker for the gamepad drive-command guard: predicts every result and compares it.
`timescale 1ns / 1ps

module gdcg_checker #(
    parameter int AXIS_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_cfg_wr_en,
    input  logic [gdcg_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [gdcg_pkg::CFG_DATA_W-1:0]  i_cfg_wr_data,

    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic                             i_op,
    input  logic                             i_sample_complete,
    input  logic signed [AXIS_BITS-1:0]      i_brake_axis_value,
    input  logic signed [AXIS_BITS-1:0]      i_throttle_axis_value,
    input  logic signed [AXIS_BITS-1:0]      i_steering_axis_value,
    input  logic                             i_start_pressed,
    input  logic                             i_back_pressed,

    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic                             i_kind,
    input  logic                             i_enable_value,
    input  logic [AXIS_BITS-1:0]             i_brake_cmd,
    input  logic [AXIS_BITS-1:0]             i_throttle_cmd,
    input  logic signed [AXIS_BITS-1:0]      i_steering_cmd,

    output int                               o_mismatches,
    output int                               o_pending,
    output int                               o_compared
);
    import gdcg_pkg::*;

    localparam longint AXIS_ONE  = longint'(1) <<< (AXIS_BITS - 1);
    localparam longint ARM_LEVEL = (99 * AXIS_ONE) / 100;
    localparam longint GAIN_ONE  = 32768;
    localparam int     REPORT_LIMIT = 10;

    typedef logic signed [AXIS_BITS-1:0] t_axis;

    typedef struct packed {
        t_kind                kind;
        logic                 enable;
        logic [AXIS_BITS-1:0] brake;
        logic [AXIS_BITS-1:0] throttle;
        logic [AXIS_BITS-1:0] steering;
    } t_guard_msg;

    // Register copies.
    logic [GAIN_W-1:0] smoothing_coeff;
    logic [TICK_W-1:0] timeout_ticks;
    logic [GAIN_W-1:0] brake_gain;
    logic [GAIN_W-1:0] throttle_gain;
    logic [GAIN_W-1:0] steering_gain;

    // Guard state.
    bit                armed;
    bit                enabled;
    bit                last_start;
    bit                last_back;
    bit                got_sample;
    logic [TICK_W-1:0] quiet_ticks;
    longint            brake_lvl;
    longint            throttle_lvl;
    longint            steer_lvl;
    longint            steer_avg;

    t_guard_msg awaited_msgs[$];
    int         mismatches;
    int         compared;

    // Divide by 2^sh, rounding to nearest with halves going up.
    function automatic longint round_half_up(longint p, int sh);
        return (p + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Trigger travel (1 - v) / 2 scaled by a Q1.15 gain, held to [0, 1].
    function automatic longint pedal_level(t_axis axis, logic [GAIN_W-1:0] gain);
        longint travel;
        travel = AXIS_ONE - longint'(axis);
        return sat(round_half_up(longint'(gain) * travel, 16), 0, AXIS_ONE);
    endfunction

    function automatic string show(t_guard_msg m);
        return $sformatf("kind %0d en %0b brake %0d throttle %0d steering %0d",
                         m.kind, m.enable, m.brake, m.throttle, $signed(m.steering));
    endfunction

    // Advances the guard state by one transaction and returns the message it causes.
    task automatic guard_respond(input t_op op, input logic complete,
                                 input t_axis b, input t_axis t, input t_axis s,
                                 input logic start, input logic back,
                                 output bit emits, output t_guard_msg msg);
        longint neg;
        longint mix;
        emits = 1'b0;
        msg   = '0;
        if (op == OP_SAMPLE) begin
            if (!complete) return;
            got_sample  = 1'b1;
            quiet_ticks = '0;
            if (!armed) begin
                // The arming sample touches neither levels nor button history.
                if (longint'(b) > ARM_LEVEL && longint'(t) > ARM_LEVEL) armed = 1'b1;
                return;
            end
            brake_lvl    = pedal_level(b, brake_gain);
            throttle_lvl = pedal_level(t, throttle_gain);
            neg          = sat(-longint'(s), -AXIS_ONE, AXIS_ONE - 1);
            steer_lvl    = sat(round_half_up(longint'(steering_gain) * neg, 15),
                               -AXIS_ONE, AXIS_ONE - 1);
            if (!last_back && back) begin
                enabled    = 1'b0;
                emits      = 1'b1;
                msg.kind   = KIND_ENABLE;
                msg.enable = 1'b0;
            end else if (!last_start && start) begin
                enabled    = 1'b1;
                emits      = 1'b1;
                msg.kind   = KIND_ENABLE;
                msg.enable = 1'b1;
            end
            last_back  = back;
            last_start = start;
            return;
        end
        if (quiet_ticks != TICK_MAX) quiet_ticks = quiet_ticks + 1'b1;
        if (enabled && got_sample && quiet_ticks > timeout_ticks) begin
            brake_lvl    = 0;
            throttle_lvl = 0;
            steer_lvl    = 0;
            steer_avg    = 0;
            armed        = 1'b0;
            enabled      = 1'b0;
            emits        = 1'b1;
            msg.kind     = KIND_ENABLE;
            msg.enable   = 1'b0;
            return;
        end
        if (!enabled) return;
        mix = longint'(smoothing_coeff) * steer_lvl
            + (GAIN_ONE - longint'(smoothing_coeff)) * steer_avg;
        steer_avg    = sat(round_half_up(mix, 15), -AXIS_ONE, AXIS_ONE - 1);
        emits        = 1'b1;
        msg.kind     = KIND_DRIVE;
        msg.brake    = brake_lvl[AXIS_BITS-1:0];
        msg.throttle = throttle_lvl[AXIS_BITS-1:0];
        msg.steering = steer_avg[AXIS_BITS-1:0];
    endtask

    always @(posedge i_clk) begin : watch
        t_guard_msg got;
        t_guard_msg want;
        t_guard_msg fresh;
        bit         emits;
        if (!i_rst_n) begin
            smoothing_coeff = SMOOTHING_COEFF_RST;
            timeout_ticks   = TIMEOUT_TICKS_RST;
            brake_gain      = GAIN_RST;
            throttle_gain   = GAIN_RST;
            steering_gain   = GAIN_RST;
            armed           = 1'b0;
            enabled         = 1'b0;
            last_start      = 1'b0;
            last_back       = 1'b0;
            got_sample      = 1'b0;
            quiet_ticks     = '0;
            brake_lvl       = 0;
            throttle_lvl    = 0;
            steer_lvl       = 0;
            steer_avg       = 0;
            mismatches      = 0;
            compared        = 0;
            awaited_msgs.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_SMOOTHING_COEFF: smoothing_coeff = i_cfg_wr_data;
                    CFG_TIMEOUT_TICKS:   timeout_ticks   = i_cfg_wr_data[TICK_W-1:0];
                    CFG_BRAKE_GAIN:      brake_gain      = i_cfg_wr_data;
                    CFG_THROTTLE_GAIN:   throttle_gain   = i_cfg_wr_data;
                    CFG_STEERING_GAIN:   steering_gain   = i_cfg_wr_data;
                    default: ;
                endcase
            end

            if (i_out_valid && !i_out_stall) begin
                got.kind     = t_kind'(i_kind);
                got.enable   = i_enable_value;
                got.brake    = i_brake_cmd;
                got.throttle = i_throttle_cmd;
                got.steering = i_steering_cmd;
                compared++;
                if (awaited_msgs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("result %0d arrived with nothing awaited: %s",
                                 compared, show(got));
                end else begin
                    want = awaited_msgs.pop_front();
                    if (got.kind !== want.kind || got.enable !== want.enable
                            || got.brake !== want.brake || got.throttle !== want.throttle
                            || got.steering !== want.steering) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("result %0d differs: expected %s, got %s",
                                     compared, show(want), show(got));
                    end
                end
            end

            if (i_in_valid && !i_in_stall) begin
                guard_respond(t_op'(i_op), i_sample_complete, i_brake_axis_value,
                              i_throttle_axis_value, i_steering_axis_value,
                              i_start_pressed, i_back_pressed, emits, fresh);
                if (emits) awaited_msgs.push_back(fresh);
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= awaited_msgs.size();
        o_compared   <= compared;
    end

endmodule

/* tb/tb_top.sv */
// Testbench top for the gamepad drive-command guard: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb_top;
    import gdcg_pkg::*;

    localparam int AXIS_BITS = 16;
    localparam int AX_MAX    = 2 ** (AXIS_BITS - 1) - 1;
    localparam int AX_MIN    = -(2 ** (AXIS_BITS - 1));
    // Raw trigger reading that sits exactly at 0.99; arming needs more than this.
    localparam int ARM_RAW   = (99 * 2 ** (AXIS_BITS - 1)) / 100;

    // A transaction passes the input register and then the result register, so
    // DRAIN_CYCLES idle cycles cover any transaction still in flight without a result.
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 64;
    localparam int CYCLE_LIMIT  = 2_000_000;

    typedef logic signed [AXIS_BITS-1:0] t_axis;

    localparam t_axis AXIS_HI  = t_axis'(AX_MAX);
    localparam t_axis AXIS_LO  = t_axis'(AX_MIN);
    localparam t_axis AXIS_ARM = t_axis'(ARM_RAW);

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_wr_en    = 1'b0;
    t_cfg_index             cfg_index    = CFG_SMOOTHING_COEFF;
    logic [CFG_DATA_W-1:0]  cfg_wr_data  = '0;
    logic                   in_valid     = 1'b0;
    logic                   in_stall;
    t_op                    in_op        = OP_SAMPLE;
    logic                   in_complete  = 1'b0;
    t_axis                  in_brake     = '0;
    t_axis                  in_throttle  = '0;
    t_axis                  in_steering  = '0;
    logic                   in_start     = 1'b0;
    logic                   in_back      = 1'b0;
    logic                   out_valid;
    logic                   out_stall    = 1'b0;
    logic                   out_kind;
    logic                   out_enable;
    logic [AXIS_BITS-1:0]   out_brake;
    logic [AXIS_BITS-1:0]   out_throttle;
    t_axis                  out_steering;

    int chk_mismatches;
    int chk_pending;
    int chk_compared;

    // Stimulus bookkeeping, touched only by the stimulus process.
    bit idle_off      = 1'b0;
    int cur_timeout   = int'(TIMEOUT_TICKS_RST);
    int items_sent    = 0;
    int ticks_sent    = 0;
    int settings_used = 1;

    // The stimulus asks for a long receiver hold-off by bumping hold_reqs; the
    // stall process serves each request once and counts the hold itself.
    int hold_reqs   = 0;
    int hold_served = 0;
    int hold_left   = 0;
    int run_left    = 0;
    int cycles      = 0;

    gamepad_drive_command_guard #(
        .AXIS_BITS(AXIS_BITS)
    ) u_dut (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_cfg_wr_en           (cfg_wr_en),
        .i_cfg_index           (cfg_index),
        .i_cfg_wr_data         (cfg_wr_data),
        .i_in_valid            (in_valid),
        .o_in_stall            (in_stall),
        .i_op                  (in_op),
        .i_sample_complete     (in_complete),
        .i_brake_axis_value    (in_brake),
        .i_throttle_axis_value (in_throttle),
        .i_steering_axis_value (in_steering),
        .i_start_pressed       (in_start),
        .i_back_pressed        (in_back),
        .o_out_valid           (out_valid),
        .i_out_stall           (out_stall),
        .o_kind                (out_kind),
        .o_enable_value        (out_enable),
        .o_brake_cmd           (out_brake),
        .o_throttle_cmd        (out_throttle),
        .o_steering_cmd        (out_steering)
    );

    gdcg_checker #(
        .AXIS_BITS(AXIS_BITS)
    ) u_checker (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_cfg_wr_en           (cfg_wr_en),
        .i_cfg_index           (cfg_index),
        .i_cfg_wr_data         (cfg_wr_data),
        .i_in_valid            (in_valid),
        .i_in_stall            (in_stall),
        .i_op                  (in_op),
        .i_sample_complete     (in_complete),
        .i_brake_axis_value    (in_brake),
        .i_throttle_axis_value (in_throttle),
        .i_steering_axis_value (in_steering),
        .i_start_pressed       (in_start),
        .i_back_pressed        (in_back),
        .i_out_valid           (out_valid),
        .i_out_stall           (out_stall),
        .i_kind                (out_kind),
        .i_enable_value        (out_enable),
        .i_brake_cmd           (out_brake),
        .i_throttle_cmd        (out_throttle),
        .i_steering_cmd        (out_steering),
        .o_mismatches          (chk_mismatches),
        .o_pending             (chk_pending),
        .o_compared            (chk_compared)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: a correct run ends far below this.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d results still awaited.",
                     cycles, chk_pending);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver stalls: mostly short bursts, a few long ones, quiet stretches
    // with no stalls at all, and the requested long hold-offs.
    always @(posedge clk) begin : receiver
        int pick;
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_reqs != hold_served) begin
            out_stall   <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end else if (run_left != 0) begin
            run_left <= run_left - 1;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                out_stall <= 1'b0;
                run_left  <= $urandom_range(0, 6);
            end else if (pick < 60) begin
                out_stall <= 1'b0;
                run_left  <= $urandom_range(50, 200);
            end else if (pick < 95) begin
                out_stall <= 1'b1;
                run_left  <= $urandom_range(0, 2);
            end else begin
                out_stall <= 1'b1;
                run_left  <= $urandom_range(10, 40);
            end
        end
    end

    // Sender gaps: most transactions follow back to back or after a short
    // gap, a few wait for a long while.
    function automatic int idle_gap();
        int pick;
        if (idle_off) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 8);
        return $urandom_range(12, 40);
    endfunction

    // Axis values lean on the full-scale ends, the arming threshold and zero.
    function automatic t_axis rand_axis();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 1) ? AXIS_HI : AXIS_LO;
            1: return t_axis'(ARM_RAW - 1 + $urandom_range(0, 2));
            2: return t_axis'(int'($urandom_range(0, 4)) - 2);
            default: return t_axis'($urandom);
        endcase
    endfunction

    function automatic t_axis arm_axis();
        return t_axis'($urandom_range(ARM_RAW - 1, AX_MAX));
    endfunction

    // Offers one transaction and returns at the edge where it is accepted.
    // Valid stays high on return so that the next transaction can follow
    // without a bubble; it is lowered only when a gap is wanted.
    task automatic send(input t_op op, input logic complete,
                        input t_axis b, input t_axis t, input t_axis s,
                        input logic start, input logic back);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        in_op       <= op;
        in_complete <= complete;
        in_brake    <= b;
        in_throttle <= t;
        in_steering <= s;
        in_start    <= start;
        in_back     <= back;
        do @(posedge clk); while (in_stall);
        if (op == OP_TICK) ticks_sent++;
        if (op == OP_TICK || complete) items_sent++;
    endtask

    task automatic sample(input t_axis b, input t_axis t, input t_axis s,
                          input logic start, input logic back);
        send(OP_SAMPLE, 1'b1, b, t, s, start, back);
    endtask

    // The payload of a tick carries no meaning, so it is left random.
    task automatic send_tick();
        send(OP_TICK, 1'($urandom_range(0, 1)), rand_axis(), rand_axis(), rand_axis(),
             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    // Arms the guard if needed, clears the button history and raises start,
    // which leaves control enabled whatever the state was before.
    task automatic enable_sequence();
        sample(t_axis'($urandom_range(ARM_RAW + 1, AX_MAX)),
               t_axis'($urandom_range(ARM_RAW + 1, AX_MAX)), rand_axis(), 1'b0, 1'b0);
        sample(rand_axis(), rand_axis(), rand_axis(), 1'b0, 1'b0);
        sample(rand_axis(), rand_axis(), rand_axis(), 1'b1, 1'b0);
    endtask

    // Stops offering and waits until every awaited result has been taken.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (chk_pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge clk);
    endtask

    // Registers change only once the guard has gone quiet.
    task automatic write_config(input logic [CFG_DATA_W-1:0] coeff,
                                input logic [TICK_W-1:0] timeout,
                                input logic [CFG_DATA_W-1:0] b_gain,
                                input logic [CFG_DATA_W-1:0] t_gain,
                                input logic [CFG_DATA_W-1:0] s_gain);
        settle();
        write_reg(CFG_SMOOTHING_COEFF, coeff);
        write_reg(CFG_TIMEOUT_TICKS, CFG_DATA_W'(timeout));
        write_reg(CFG_BRAKE_GAIN, b_gain);
        write_reg(CFG_THROTTLE_GAIN, t_gain);
        write_reg(CFG_STEERING_GAIN, s_gain);
        cfg_wr_en   <= 1'b0;
        cur_timeout = int'(timeout);
        settings_used++;
    endtask

    // One random step. Most of the mix keeps the guard armed and enabled so
    // that drive commands flow; the rest is button noise, dropped samples,
    // re-arming attempts near the threshold and tick runs that outlast the
    // timeout.
    task automatic random_item();
        int pick;
        int run;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            send_tick();
        end else if (pick < 72) begin
            sample(rand_axis(), rand_axis(), rand_axis(),
                   $urandom_range(0, 99) < 35, $urandom_range(0, 99) < 12);
        end else if (pick < 78) begin
            send(OP_SAMPLE, 1'b0, rand_axis(), rand_axis(), rand_axis(),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else if (pick < 84) begin
            sample(arm_axis(), arm_axis(), rand_axis(),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else if (pick < 91) begin
            enable_sequence();
        end else if (pick < 96) begin
            run = (cur_timeout <= 40) ? cur_timeout + 1 : 3;
            repeat (run) send_tick();
        end else if (pick < 99) begin
            sample(rand_axis(), rand_axis(), rand_axis(), 1'b1, 1'b1);
        end else begin
            settle();
        end
    endtask

    task automatic run_random(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) random_item();
    endtask

    function automatic logic [CFG_DATA_W-1:0] rand_gain();
        return CFG_DATA_W'($urandom_range(0, GAIN_RST));
    endfunction

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset register values.
        // A tick before any sample does nothing.
        send_tick();
        // A dropped sample must not arm, even with both triggers released.
        send(OP_SAMPLE, 1'b0, AXIS_HI, AXIS_HI, AXIS_LO, 1'b1, 1'b1);
        // Exactly 0.99 on either trigger is not enough to arm.
        sample(AXIS_ARM, AXIS_HI, '0, 1'b0, 1'b0);
        sample(AXIS_HI, AXIS_ARM, '0, 1'b0, 1'b0);
        // Arming sample: pressed buttons here must not count as history.
        sample(AXIS_ARM + 1'b1, AXIS_ARM + 1'b1, '0, 1'b1, 1'b1);
        // Both buttons already high: back wins and a disable comes out.
        sample(AXIS_LO, AXIS_HI, AXIS_LO, 1'b1, 1'b1);
        sample(AXIS_HI, AXIS_LO, AXIS_HI, 1'b0, 1'b0);
        sample(AXIS_LO, AXIS_LO, AXIS_LO, 1'b1, 1'b0);
        send_tick();
        // Back rising while start is held disables.
        sample('0, '0, '0, 1'b1, 1'b1);
        sample('0, '0, '0, 1'b0, 1'b0);
        // Start and back rising together: back has priority.
        sample(AXIS_HI, AXIS_LO, AXIS_HI, 1'b1, 1'b1);
        sample(AXIS_HI, AXIS_LO, AXIS_HI, 1'b1, 1'b0);
        sample(AXIS_LO, AXIS_HI, t_axis'(-1), 1'b0, 1'b0);
        sample(AXIS_LO, AXIS_HI, t_axis'(-1), 1'b1, 1'b0);
        // A second start edge while enabled still reports the enable.
        sample(AXIS_HI, AXIS_HI, t_axis'(1), 1'b0, 1'b0);
        sample(AXIS_HI, AXIS_HI, t_axis'(1), 1'b1, 1'b0);
        send_tick();
        send_tick();
        // A second back edge while disabled still reports the disable.
        sample('0, '0, AXIS_LO, 1'b0, 1'b1);
        sample('0, '0, AXIS_LO, 1'b0, 1'b0);
        sample('0, '0, AXIS_LO, 1'b0, 1'b1);
        send_tick();

        // Fill the guard: the receiver holds off while ticks keep coming.
        enable_sequence();
        hold_reqs <= hold_reqs + 1;
        idle_off = 1'b1;
        repeat (12) send_tick();
        idle_off = 1'b0;
        run_random(150);

        // No smoothing, unity gains and the shortest timeout.
        write_config(GAIN_RST, 10'd1, GAIN_RST, GAIN_RST, GAIN_RST);
        run_random(170);
        // Heaviest smoothing in range and all outputs scaled to zero.
        write_config(16'd328, 10'd3, '0, '0, '0);
        run_random(170);
        // Random in-range setting.
        write_config(CFG_DATA_W'($urandom_range(328, 32768)), TICK_W'($urandom_range(2, 20)),
                     rand_gain(), rand_gain(), rand_gain());
        run_random(170);
        // Out-of-range gains and coefficient let the outputs reach saturation.
        write_config(16'hFFFF, 10'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(170);
        // Zero coefficient freezes the average; mixed gains.
        write_config('0, 10'd5, 16'd16384, 16'd1, 16'd32767);
        run_random(170);

        // Longest timeout in range: it trips on the 1001st silent tick.
        write_config(CFG_DATA_W'($urandom_range(328, 32768)), 10'd1000,
                     rand_gain(), rand_gain(), rand_gain());
        enable_sequence();
        idle_off = 1'b1;
        repeat (1001) send_tick();
        idle_off = 1'b0;
        // With the largest count the tick counter saturates and never trips.
        write_config(CFG_DATA_W'($urandom_range(328, 32768)), TICK_MAX,
                     rand_gain(), rand_gain(), rand_gain());
        enable_sequence();
        idle_off = 1'b1;
        repeat (1030) send_tick();
        idle_off = 1'b0;
        run_random(60);

        settle();
        $display("Sent %0d transactions (%0d ticks) under %0d register settings,",
                 items_sent, ticks_sent, settings_used);
        $display("including long silences; %0d results compared, %0d mismatched.",
                 chk_compared, chk_mismatches);
        if (chk_mismatches == 0 && chk_pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
